### hw/rtl/cluster_barrier_and_irq_unit_defines.svh
// Assertion macros for the cluster barrier and interrupt unit checker
`ifndef CLUSTER_BARRIER_AND_IRQ_UNIT_DEFINES_SVH
`define CLUSTER_BARRIER_AND_IRQ_UNIT_DEFINES_SVH

// same-cycle implication, held off during reset
`define CBIU_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked through reset as well
`define CBIU_ASSERT_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hw/rtl/cbiu_pkg.sv
// Package for the cluster barrier and interrupt unit: constants, codes, field layout
`default_nettype none
package cbiu_pkg;

  localparam int NUM_CORES   = 8;
  localparam int CORE_MASK_W = NUM_CORES;
  localparam int WIDE_W      = (NUM_CORES > 8) ? NUM_CORES : 8;

  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 24;

  localparam logic [CORE_MASK_W-1:0] ALL_CORES = {CORE_MASK_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_BARRIER   = 2'd0,
    CMD_IRQ_SET   = 2'd1,
    CMD_IRQ_CLEAR = 2'd2
  } cmd_t;

  // interrupt bits that map to an existing core
  function automatic logic [7:0] irq_valid_mask();
    logic [7:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      m[i] = (i < NUM_CORES);
    end
    return m;
  endfunction

  function automatic logic [7:0] mask_to_byte(input logic [CORE_MASK_W-1:0] m);
    logic [WIDE_W-1:0] w;
    w = WIDE_W'(m);
    return w[7:0];
  endfunction

endpackage
`default_nettype wire

### hw/rtl/cluster_barrier_and_irq_unit.sv
// The result of an input transaction is registered and appears on the master side in the cycle after it is accepted.
// Throughput: one transaction per cycle; s_tready follows m_tready or an empty
// result register, so the only back-pressure comes from the output register.
// Reset (rst, synchronous, active high) clears the arrival and waiting masks,
// lowers all interrupt lines and empties the result register.
`default_nettype none
module cluster_barrier_and_irq_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // [2:0] core_id, [10:3] bit_mask, [15:11] zero
  input  wire logic [cbiu_pkg::IN_DATA_W-1:0] s_tdata,
  // [1:0] command, [2] from_core_port
  input  wire logic [cbiu_pkg::IN_USER_W-1:0] s_tuser,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // [0] stall_requester, [1] barrier_done, [9:2] release_mask, [17:10] irq_levels,
  // [23:18] zero
  output logic [cbiu_pkg::OUT_DATA_W-1:0]     m_tdata
);

  logic [cbiu_pkg::CORE_MASK_W-1:0] arrived, arrived_next;
  logic [cbiu_pkg::CORE_MASK_W-1:0] waiting, waiting_next;
  logic [7:0]                       irq_state, irq_state_next;
  logic [cbiu_pkg::OUT_DATA_W-1:0]  out_data, out_data_next;
  logic                             out_valid;

  cbiu_pkg::cmd_t                   command;
  logic                             from_core_port;
  logic [2:0]                       core_id;
  logic [7:0]                       bit_mask;
  logic [cbiu_pkg::CORE_MASK_W-1:0] core_hit, arrived_set;
  logic                             core_ok;
  logic                             stall, done;
  logic [cbiu_pkg::CORE_MASK_W-1:0] release_set;
  logic                             accept;

  assign command        = cbiu_pkg::cmd_t'(s_tuser[1:0]);
  assign from_core_port = s_tuser[2];
  assign core_id        = s_tdata[2:0];
  assign bit_mask       = s_tdata[10:3] & cbiu_pkg::irq_valid_mask();

  assign s_tready = !out_valid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  assign core_hit    = cbiu_pkg::CORE_MASK_W'(1) << core_id;
  assign core_ok     = 32'(core_id) < cbiu_pkg::NUM_CORES;
  assign arrived_set = arrived | core_hit;

  always_comb begin
    arrived_next   = arrived;
    waiting_next   = waiting;
    irq_state_next = irq_state;
    stall          = 1'b0;
    done           = 1'b0;
    release_set    = '0;
    unique case (command)
      cbiu_pkg::CMD_BARRIER: begin
        if (from_core_port && core_ok) begin
          if (arrived_set == cbiu_pkg::ALL_CORES) begin
            done         = 1'b1;
            release_set  = waiting;
            arrived_next = '0;
            waiting_next = '0;
          end else begin
            stall        = 1'b1;
            arrived_next = arrived_set;
            waiting_next = waiting | core_hit;
          end
        end
      end
      cbiu_pkg::CMD_IRQ_SET:   irq_state_next = irq_state | bit_mask;
      cbiu_pkg::CMD_IRQ_CLEAR: irq_state_next = irq_state & ~bit_mask;
      default: ;
    endcase
    out_data_next = {6'd0, irq_state_next, cbiu_pkg::mask_to_byte(release_set), done, stall};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      arrived   <= '0;
      waiting   <= '0;
      irq_state <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        arrived   <= arrived_next;
        waiting   <= waiting_next;
        irq_state <= irq_state_next;
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= out_data_next;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/cbiu_checker.sv
// Port-level checker for the cluster barrier and interrupt unit, with its bind
`default_nettype none
`include "cluster_barrier_and_irq_unit_defines.svh"
module cbiu_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           s_tvalid,
  input wire logic                           s_tready,
  input wire logic [cbiu_pkg::IN_DATA_W-1:0] s_tdata,
  input wire logic [cbiu_pkg::IN_USER_W-1:0] s_tuser,
  input wire logic                           m_tvalid,
  input wire logic                           m_tready,
  input wire logic [cbiu_pkg::OUT_DATA_W-1:0] m_tdata
);

  // a stalled result holds
  `CBIU_ASSERT_NEXT(a_out_hold, clk, !rst && m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  // reset empties the result register
  `CBIU_ASSERT_NEXT(a_rst_empty, clk, rst, !m_tvalid)
  // input side is held only by a full, stalled result register
  `CBIU_ASSERT_IMPLY(a_ready, clk, rst, 1'b1, s_tready == (!m_tvalid || m_tready))
  // a transaction never both stalls and completes the barrier
  `CBIU_ASSERT_IMPLY(a_excl, clk, rst, m_tvalid, !(m_tdata[0] && m_tdata[1]))
  // cores are released only on completion
  `CBIU_ASSERT_IMPLY(a_release, clk, rst, m_tvalid && !m_tdata[1], m_tdata[9:2] == 8'd0)

endmodule

bind cluster_barrier_and_irq_unit cbiu_checker u_cbiu_checker (.*);
`default_nettype wire

### dv/cluster_barrier_and_irq_unit_checker.sv
// Checker for the cluster barrier and interrupt unit: tracks transactions, predicts, compares
module cluster_barrier_and_irq_unit_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [cbiu_pkg::IN_DATA_W-1:0] s_tdata,
  input  logic [cbiu_pkg::IN_USER_W-1:0] s_tuser,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [cbiu_pkg::OUT_DATA_W-1:0] m_tdata,
  output int                             errors,
  output int                             outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NC = cbiu_pkg::NUM_CORES;
  localparam logic [31:0] ALL_MASK = (NC >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << NC) - 1);

  typedef struct packed {
    logic       stall;
    logic       done;
    logic [7:0] release_mask;
    logic [7:0] irq;
  } barrier_result_t;

  logic [31:0]     arrivals;
  logic [31:0]     waiters;
  logic [31:0]     irq_lines;
  barrier_result_t expected_results[$];
  barrier_result_t got;
  barrier_result_t want;

  function automatic barrier_result_t predict_access(input logic [1:0] cmd,
                                                     input logic       core_port,
                                                     input logic [2:0] core,
                                                     input logic [7:0] bits);
    barrier_result_t r;
    logic [31:0]     m;
    r = '0;
    m = 32'(bits) & ALL_MASK;
    if (cmd == cbiu_pkg::CMD_BARRIER) begin
      if (core_port && int'(core) < NC) begin
        arrivals |= 32'd1 << core;
        if (arrivals == ALL_MASK) begin
          r.done         = 1'b1;
          r.release_mask = waiters[7:0];
          arrivals       = '0;
          waiters        = '0;
        end else begin
          waiters |= 32'd1 << core;
          r.stall  = 1'b1;
        end
      end
    end else if (cmd == cbiu_pkg::CMD_IRQ_SET) begin
      irq_lines |= m;
    end else if (cmd == cbiu_pkg::CMD_IRQ_CLEAR) begin
      irq_lines &= ~m;
    end
    r.irq = irq_lines[7:0];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    $display("%0t ns: %s", $time, msg);
  endtask

  initial begin
    errors      = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      arrivals  = '0;
      waiters   = '0;
      irq_lines = '0;
      expected_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.stall        = m_tdata[0];
        got.done         = m_tdata[1];
        got.release_mask = m_tdata[9:2];
        got.irq          = m_tdata[17:10];
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result %h with no transaction pending", m_tdata));
        end else begin
          want = expected_results.pop_front();
          if (got.stall != want.stall)
            report_mismatch($sformatf("stall_requester %b, want %b", got.stall, want.stall));
          if (got.done != want.done)
            report_mismatch($sformatf("barrier_done %b, want %b", got.done, want.done));
          if (got.release_mask != want.release_mask)
            report_mismatch($sformatf("release_mask %h, want %h",
                                      got.release_mask, want.release_mask));
          if (got.irq != want.irq)
            report_mismatch($sformatf("irq_levels %h, want %h", got.irq, want.irq));
        end
      end
      if (s_tvalid && s_tready)
        expected_results.push_back(predict_access(s_tuser[1:0], s_tuser[2],
                                                  s_tdata[2:0], s_tdata[10:3]));
    end
    outstanding = expected_results.size();
  end

endmodule

### dv/cluster_barrier_and_irq_unit_tb.sv
// Testbench top for the cluster barrier and interrupt unit: clock, reset, stimulus, verdict
module cluster_barrier_and_irq_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int         N_ITEMS    = 1600;

  logic                            clk;
  logic                            rst;
  logic                            s_tvalid;
  logic                            s_tready;
  logic [cbiu_pkg::IN_DATA_W-1:0]  s_tdata;
  logic [cbiu_pkg::IN_USER_W-1:0]  s_tuser;
  logic                            m_tvalid;
  logic                            m_tready;
  logic [cbiu_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                            s_hs;
  bit                              no_idle;
  int                              errors;
  int                              outstanding;
  int                              items_sent;
  bit                              drained_mid;

  cluster_barrier_and_irq_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  cluster_barrier_and_irq_unit_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // input transaction seen at the last rising edge
  always @(posedge clk) s_hs <= s_tvalid && s_tready;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // called and returns at a falling edge
  task automatic send_access(input logic [1:0] cmd, input logic core_port,
                             input logic [2:0] core, input logic [7:0] bits);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= {core_port, cmd};
    s_tdata  <= {5'b0, bits, core};
    do @(negedge clk); while (!s_hs);
    items_sent++;
  endtask

  task automatic random_access();
    if ($urandom_range(0, 1) == 0)
      send_access($urandom_range(0, 1) ? cbiu_pkg::CMD_IRQ_SET : cbiu_pkg::CMD_IRQ_CLEAR,
                  1'($urandom), 3'($urandom), 8'($urandom));
    else
      send_access(2'($urandom), 1'($urandom), 3'($urandom), 8'($urandom));
  endtask

  // every core arrives once in shuffled order, with repeats and interleaved writes;
  // a few rounds are cut short
  task automatic barrier_round();
    int order[8];
    int stop_at;
    int j;
    int t;
    for (int i = 0; i < 8; i++) order[i] = i;
    for (int i = 7; i > 0; i--) begin
      j        = $urandom_range(0, i);
      t        = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    stop_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 7) : 8;
    for (int i = 0; i < stop_at; i++) begin
      if ($urandom_range(0, 4) == 0) random_access();
      if (i > 0 && $urandom_range(0, 5) == 0)
        send_access(cbiu_pkg::CMD_BARRIER, 1'b1, 3'(order[$urandom_range(0, i - 1)]),
                    8'($urandom));
      send_access(cbiu_pkg::CMD_BARRIER, 1'b1, 3'(order[i]), 8'($urandom));
    end
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  initial begin
    int n;
    m_tready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      n = pick_gap();
      if (n > 0) begin
        m_tready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  end

  initial begin
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = '0;
    no_idle     = 1'b0;
    items_sent  = 0;
    drained_mid = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_access(cbiu_pkg::CMD_IRQ_SET,   1'b1, 3'd7, 8'hFF);
    send_access(cbiu_pkg::CMD_IRQ_CLEAR, 1'b0, 3'd0, 8'hAA);
    send_access(cbiu_pkg::CMD_IRQ_CLEAR, 1'b1, 3'd5, 8'h55);
    send_access(cbiu_pkg::CMD_IRQ_SET,   1'b0, 3'd2, 8'h00);
    send_access(cbiu_pkg::CMD_IRQ_SET,   1'b1, 3'd1, 8'h81);
    send_access(CMD_UNUSED,              1'b1, 3'd7, 8'hFF);
    send_access(cbiu_pkg::CMD_BARRIER,   1'b0, 3'd3, 8'hFF);
    for (int i = 0; i < 7; i++) begin
      send_access(cbiu_pkg::CMD_BARRIER, 1'b1, 3'(i), 8'h00);
      if (i == 3) send_access(cbiu_pkg::CMD_BARRIER, 1'b1, 3'd3, 8'hFF);
    end
    send_access(cbiu_pkg::CMD_BARRIER,   1'b1, 3'd7, 8'h00);
    send_access(cbiu_pkg::CMD_BARRIER,   1'b1, 3'd7, 8'h00);
    send_access(cbiu_pkg::CMD_BARRIER,   1'b0, 3'd6, 8'h00);
    send_access(CMD_UNUSED,              1'b0, 3'd0, 8'h00);
    send_access(cbiu_pkg::CMD_IRQ_CLEAR, 1'b1, 3'd0, 8'hFF);
    drain_results();

    while (items_sent < N_ITEMS) begin
      no_idle = ($urandom_range(0, 9) == 0);
      if (!drained_mid && items_sent >= N_ITEMS / 2) begin
        drain_results();
        drained_mid = 1'b1;
      end
      if ($urandom_range(0, 3) != 0) barrier_round();
      else repeat ($urandom_range(1, 6)) random_access();
    end
    no_idle = 1'b0;
    drain_results();
    repeat (10) @(negedge clk);

    if (errors == 0) begin
      $display("cluster_barrier_and_irq_unit: match");
    end else begin
      $display("cluster_barrier_and_irq_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("cluster_barrier_and_irq_unit: mismatch");
    $finish;
  end

endmodule
